// ===== rtl/core/lramt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lramt_pkg
// Shared types, codes and helpers for the lazy range-add / range-max tree.
// ----------------------------------------------------------------------------
package lramt_pkg;

  localparam int unsigned VW = 64;  // element value width
  localparam int unsigned RW = 11;  // range index field width

  typedef struct packed {
    logic [VW-1:0] max;
    logic [VW-1:0] pend;
  } node_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_NODE_RD,
    ST_NODE_UPD,
    ST_FIX_RI,
    ST_FIX_RL,
    ST_FIX_RR,
    ST_FIX_WL,
    ST_FIX_WR,
    ST_FIX_WI,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_ENTER,
    PH_LEFT_DONE,
    PH_RIGHT_DONE
  } phase_t;

  typedef enum logic [1:0] {
    RD_NODE,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_LEFT,
    WR_RIGHT,
    WR_FIX,
    WR_ADD
  } wr_sel_t;

  typedef enum logic [1:0] {
    RET_HOLD,
    RET_ZERO,
    RET_NODE,
    RET_MERGE
  } ret_sel_t;

  typedef struct packed {
    logic     load;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    logic     cap_p;
    logic     cap_l;
    logic     cap_r;
    logic     push_left;
    logic     push_right;
    logic     save_x;
    logic     pop;
    ret_sel_t ret_sel;
    logic     out_valid;
  } cmd_t;

  typedef struct packed {
    logic   clear_last;
    logic   disjoint;
    logic   covered;
    phase_t phase;
    logic   is_query;
    logic   last_frame;
  } stat_t;

  function automatic logic [VW-1:0] smax(input logic [VW-1:0] a, input logic [VW-1:0] b);
    return ($signed(b) > $signed(a)) ? b : a;
  endfunction

endpackage

// ===== rtl/core/lramt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lramt_ctrl
// Sequencer for the tree walk: clearing pass, visits, push-down and fix-up.
// ----------------------------------------------------------------------------
module lramt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  lramt_pkg::stat_t stat,
  output lramt_pkg::cmd_t  cmd
);

  lramt_pkg::state_t state, state_next;
  logic              fix_tail, fix_tail_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lramt_pkg::ST_CLEAR;
      fix_tail <= 1'b0;
    end else begin
      state    <= state_next;
      fix_tail <= fix_tail_next;
    end
  end

  // next state
  always_comb begin
    state_next    = state;
    fix_tail_next = fix_tail;
    case (state)
      lramt_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_next = lramt_pkg::ST_IDLE;
      end
      lramt_pkg::ST_IDLE: begin
        if (start) state_next = lramt_pkg::ST_VISIT;
      end
      lramt_pkg::ST_VISIT: begin
        case (stat.phase)
          lramt_pkg::PH_ENTER: begin
            if (stat.disjoint) begin
              state_next = stat.last_frame ? lramt_pkg::ST_FINISH : lramt_pkg::ST_VISIT;
            end else if (stat.covered) begin
              state_next = lramt_pkg::ST_NODE_RD;
            end else begin
              state_next    = lramt_pkg::ST_FIX_RI;
              fix_tail_next = 1'b0;
            end
          end
          lramt_pkg::PH_LEFT_DONE: state_next = lramt_pkg::ST_VISIT;
          lramt_pkg::PH_RIGHT_DONE: begin
            if (stat.is_query) begin
              state_next = stat.last_frame ? lramt_pkg::ST_FINISH : lramt_pkg::ST_VISIT;
            end else begin
              state_next    = lramt_pkg::ST_FIX_RI;
              fix_tail_next = 1'b1;
            end
          end
          default: state_next = lramt_pkg::ST_VISIT;
        endcase
      end
      lramt_pkg::ST_NODE_RD:  state_next = lramt_pkg::ST_NODE_UPD;
      lramt_pkg::ST_NODE_UPD: begin
        state_next = stat.last_frame ? lramt_pkg::ST_FINISH : lramt_pkg::ST_VISIT;
      end
      lramt_pkg::ST_FIX_RI: state_next = lramt_pkg::ST_FIX_RL;
      lramt_pkg::ST_FIX_RL: state_next = lramt_pkg::ST_FIX_RR;
      lramt_pkg::ST_FIX_RR: state_next = lramt_pkg::ST_FIX_WL;
      lramt_pkg::ST_FIX_WL: state_next = lramt_pkg::ST_FIX_WR;
      lramt_pkg::ST_FIX_WR: state_next = lramt_pkg::ST_FIX_WI;
      lramt_pkg::ST_FIX_WI: begin
        if (fix_tail && stat.last_frame) state_next = lramt_pkg::ST_FINISH;
        else                             state_next = lramt_pkg::ST_VISIT;
      end
      lramt_pkg::ST_FINISH: state_next = lramt_pkg::ST_IDLE;
      default:              state_next = lramt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.rd_sel  = lramt_pkg::RD_NODE;
    cmd.wr_sel  = lramt_pkg::WR_NONE;
    cmd.ret_sel = lramt_pkg::RET_HOLD;
    busy     = (state != lramt_pkg::ST_IDLE);
    case (state)
      lramt_pkg::ST_CLEAR: cmd.wr_sel = lramt_pkg::WR_CLEAR;
      lramt_pkg::ST_IDLE:  cmd.load = start;
      lramt_pkg::ST_VISIT: begin
        case (stat.phase)
          lramt_pkg::PH_ENTER: begin
            if (stat.disjoint) begin
              cmd.pop     = 1'b1;
              cmd.ret_sel = lramt_pkg::RET_ZERO;
            end
          end
          lramt_pkg::PH_LEFT_DONE: begin
            cmd.push_right = 1'b1;
            cmd.save_x     = stat.is_query;
          end
          lramt_pkg::PH_RIGHT_DONE: begin
            if (stat.is_query) begin
              cmd.pop     = 1'b1;
              cmd.ret_sel = lramt_pkg::RET_MERGE;
            end
          end
          default: cmd.pop = 1'b0;
        endcase
      end
      lramt_pkg::ST_NODE_RD: cmd.rd_sel = lramt_pkg::RD_NODE;
      lramt_pkg::ST_NODE_UPD: begin
        cmd.pop = 1'b1;
        if (stat.is_query) cmd.ret_sel = lramt_pkg::RET_NODE;
        else               cmd.wr_sel  = lramt_pkg::WR_ADD;
      end
      lramt_pkg::ST_FIX_RI: cmd.rd_sel = lramt_pkg::RD_NODE;
      lramt_pkg::ST_FIX_RL: begin
        cmd.rd_sel = lramt_pkg::RD_LEFT;
        cmd.cap_p  = 1'b1;
      end
      lramt_pkg::ST_FIX_RR: begin
        cmd.rd_sel = lramt_pkg::RD_RIGHT;
        cmd.cap_l  = 1'b1;
      end
      lramt_pkg::ST_FIX_WL: begin
        cmd.cap_r  = 1'b1;
        cmd.wr_sel = lramt_pkg::WR_LEFT;
      end
      lramt_pkg::ST_FIX_WR: cmd.wr_sel = lramt_pkg::WR_RIGHT;
      lramt_pkg::ST_FIX_WI: begin
        cmd.wr_sel = lramt_pkg::WR_FIX;
        if (fix_tail) cmd.pop       = 1'b1;
        else          cmd.push_left = 1'b1;
      end
      lramt_pkg::ST_FINISH: cmd.out_valid = stat.is_query;
      default: cmd.load = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/lramt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lramt_dp
// Node memory, walk stack, push-down arithmetic and result register.
// ----------------------------------------------------------------------------
module lramt_dp #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lramt_pkg::cmd_t             cmd,
  output lramt_pkg::stat_t            stat,
  input  logic                        action,
  input  logic [lramt_pkg::RW-1:0]    range_lo,
  input  logic [lramt_pkg::RW-1:0]    range_hi,
  input  logic signed [lramt_pkg::VW-1:0] delta,
  output logic                        valid,
  output logic signed [lramt_pkg::VW-1:0] max_value
);

  localparam int unsigned NODES = 2 * LEAVES;
  localparam int unsigned NW    = $clog2(NODES);
  localparam int unsigned IW    = $clog2(LEAVES + 1);
  localparam int unsigned CW    = (IW > lramt_pkg::RW) ? IW : lramt_pkg::RW;
  localparam int unsigned SD    = $clog2(LEAVES) + 1;
  localparam int unsigned TW    = $clog2(SD);
  localparam int unsigned DW    = $clog2(SD + 1);
  localparam int unsigned VW    = lramt_pkg::VW;

  lramt_pkg::node_t node_mem [NODES];
  lramt_pkg::node_t rdata, wdata;
  logic [NW-1:0]    raddr, waddr;
  logic             we;

  logic [NW-1:0]    clr_cnt;

  logic             is_query;
  logic [IW-1:0]    a_reg, b_reg;
  logic [VW-1:0]    d_reg;
  logic [CW-1:0]    lo_ext, hi_ext;

  logic [NW-1:0]       fr_node  [SD];
  logic [IW-1:0]       fr_lo    [SD];
  logic [IW-1:0]       fr_hi    [SD];
  lramt_pkg::phase_t   fr_phase [SD];
  logic [VW-1:0]       fr_x     [SD];
  logic [DW-1:0]       depth;
  logic [TW-1:0]       top, nxt;

  logic [NW-1:0]    t_node, lc, rc;
  logic [IW-1:0]    t_lo, t_hi, mid;
  logic [IW:0]      lh_sum;

  logic [VW-1:0]    p_reg, l_max, l_pend, r_max, r_pend, ret;

  assign top    = TW'(depth - DW'(1));
  assign nxt    = TW'(depth);
  assign t_node = fr_node[top];
  assign t_lo   = fr_lo[top];
  assign t_hi   = fr_hi[top];
  assign lh_sum = {1'b0, t_lo} + {1'b0, t_hi};
  assign mid    = lh_sum[IW:1];
  assign lc     = t_node + NW'(1);
  assign rc     = t_node + NW'({mid - t_lo, 1'b0});

  assign lo_ext = CW'(range_lo);
  assign hi_ext = CW'(range_hi);

  always_comb begin
    stat.clear_last = (clr_cnt == NW'(NODES - 1));
    stat.disjoint   = (a_reg >= t_hi) || (b_reg <= t_lo);
    stat.covered    = (a_reg <= t_lo) && (t_hi <= b_reg);
    stat.phase      = fr_phase[top];
    stat.is_query   = is_query;
    stat.last_frame = (depth == DW'(1));
  end

  // memory port selection
  always_comb begin
    case (cmd.rd_sel)
      lramt_pkg::RD_LEFT:  raddr = lc;
      lramt_pkg::RD_RIGHT: raddr = rc;
      default:             raddr = t_node;
    endcase
    we    = 1'b1;
    waddr = t_node;
    wdata = '0;
    case (cmd.wr_sel)
      lramt_pkg::WR_CLEAR: waddr = clr_cnt;
      lramt_pkg::WR_LEFT: begin
        waddr      = lc;
        wdata.max  = l_max;
        wdata.pend = l_pend;
      end
      lramt_pkg::WR_RIGHT: begin
        waddr      = rc;
        wdata.max  = r_max;
        wdata.pend = r_pend;
      end
      lramt_pkg::WR_FIX: wdata.max = lramt_pkg::smax(l_max, r_max);
      lramt_pkg::WR_ADD: begin
        wdata.max  = rdata.max + d_reg;
        wdata.pend = rdata.pend + d_reg;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) node_mem[waddr] <= wdata;
    rdata <= node_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      depth   <= '0;
      valid   <= 1'b0;
    end else begin
      valid <= cmd.out_valid;
      if (cmd.wr_sel == lramt_pkg::WR_CLEAR) clr_cnt <= clr_cnt + NW'(1);
      if (cmd.load)                          depth   <= DW'(1);
      else if (cmd.push_left || cmd.push_right) depth <= depth + DW'(1);
      else if (cmd.pop)                      depth   <= depth - DW'(1);
    end
  end

  // request capture with clipping to the array
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_query <= action;
      a_reg    <= (lo_ext > CW'(LEAVES)) ? IW'(LEAVES) : IW'(lo_ext);
      b_reg    <= (hi_ext > CW'(LEAVES)) ? IW'(LEAVES) : IW'(hi_ext);
      d_reg    <= delta;
    end
  end

  // walk stack
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fr_node[0]  <= '0;
      fr_lo[0]    <= '0;
      fr_hi[0]    <= IW'(LEAVES);
      fr_phase[0] <= lramt_pkg::PH_ENTER;
    end
    if (cmd.push_left) begin
      fr_phase[top] <= lramt_pkg::PH_LEFT_DONE;
      fr_node[nxt]  <= lc;
      fr_lo[nxt]    <= t_lo;
      fr_hi[nxt]    <= mid;
      fr_phase[nxt] <= lramt_pkg::PH_ENTER;
    end
    if (cmd.push_right) begin
      fr_phase[top] <= lramt_pkg::PH_RIGHT_DONE;
      fr_node[nxt]  <= rc;
      fr_lo[nxt]    <= mid;
      fr_hi[nxt]    <= t_hi;
      fr_phase[nxt] <= lramt_pkg::PH_ENTER;
    end
    if (cmd.save_x) fr_x[top] <= ret;
  end

  // push-down operands: parent pending add, then both children with it applied
  always_ff @(posedge clk) begin
    if (cmd.cap_p) p_reg <= rdata.pend;
    if (cmd.cap_l) begin
      l_max  <= rdata.max + p_reg;
      l_pend <= rdata.pend + p_reg;
    end
    if (cmd.cap_r) begin
      r_max  <= rdata.max + p_reg;
      r_pend <= rdata.pend + p_reg;
    end
    if (cmd.pop) begin
      case (cmd.ret_sel)
        lramt_pkg::RET_ZERO:  ret <= '0;
        lramt_pkg::RET_NODE:  ret <= rdata.max;
        lramt_pkg::RET_MERGE: ret <= lramt_pkg::smax(fr_x[top], ret);
        default:              ret <= ret;
      endcase
    end
    if (cmd.out_valid) max_value <= lramt_pkg::smax('0, ret);
  end

endmodule

// ===== rtl/core/lazy_range_add_range_max_tree_core.sv =====
`timescale 1ns / 1ps
// walk: an outside node is skipped, a covered node is read and updated, and a split node
//   has its pending add pushed down to both children; after an add it is fixed up again
// throughput: one item at a time, the next start is taken once busy falls
// a query strobes valid for one cycle with max_value; an add gives no result
// reset: synchronous; a clearing pass zeroes all 2*LEAVES node memory entries,
//   busy stays high until it ends; results cannot be stalled
// ----------------------------------------------------------------------------
// lazy_range_add_range_max_tree_core
// Segment tree with lazy pending adds: range add and range maximum query.
// ----------------------------------------------------------------------------
module lazy_range_add_range_max_tree_core #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic [lramt_pkg::RW-1:0]        range_lo,
  input  logic [lramt_pkg::RW-1:0]        range_hi,
  input  logic signed [lramt_pkg::VW-1:0] delta,
  output logic                            valid,
  output logic signed [lramt_pkg::VW-1:0] max_value
);

  lramt_pkg::cmd_t  cmd;
  lramt_pkg::stat_t stat;

  lramt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lramt_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .action    (action),
    .range_lo  (range_lo),
    .range_hi  (range_hi),
    .delta     (delta),
    .valid     (valid),
    .max_value (max_value)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting a word");

  a_valid_from_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy))
    else $error("result strobe without a word in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid)
    else $error("result strobe longer than one cycle");

  a_nonneg_result: assert property (@(posedge clk) disable iff (rst)
    valid |-> !max_value[lramt_pkg::VW-1])
    else $error("negative result word");

endmodule
